### hw/rtl/pse_pkg.sv
`default_nettype none
package pse_pkg;

  localparam int DIM_W = 14;
  localparam int RAW_W = 30;
  localparam int LEN_W = 32;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [15:0] BLOCK_MAX = 16'hffff;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [31:0] CRC_POLY  = 32'hedb88320;
  localparam logic [31:0] CRC_INIT  = 32'hffffffff;
  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;

  typedef struct packed {
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pse_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_image;
  } pse_out_t;

  // One record per accepted item that produces output.
  typedef struct packed {
    logic             is_start;
    logic             filter;   // row starts with this pixel
    logic             finish;   // last pixel of the image
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [31:0]      pixel;    // R,G,B,A from the top byte down
  } pse_cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] sig_byte(input logic [2:0] i);
    logic [7:0] v;
    case (i)
      3'd0:    v = 8'd137;
      3'd1:    v = 8'd80;
      3'd2:    v = 8'd78;
      3'd3:    v = 8'd71;
      3'd4:    v = 8'd13;
      3'd5:    v = 8'd10;
      3'd6:    v = 8'd26;
      default: v = 8'd10;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/pse_front.sv
`default_nettype none
module pse_front import pse_pkg::*; #(
  parameter int MAX_DIMENSION = 8192
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire pse_in_t          in_item,
  input  wire logic [DIM_W-1:0] image_width,
  input  wire logic [DIM_W-1:0] image_height,
  output logic                  cmd_push,
  output pse_cmd_t              cmd_data,
  input  wire logic             cmd_full
);

  localparam logic [DIM_W:0] MAX_D = (DIM_W+1)'(MAX_DIMENSION);

  logic             image_open;
  logic [DIM_W-1:0] latched_width;
  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] rows_remaining;

  logic             accept;
  logic [DIM_W-1:0] w_clamp, h_clamp, col_next, rows_next;
  logic             filter;

  function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if ({1'b0, v} > MAX_D) return MAX_D[DIM_W-1:0];
    return v;
  endfunction

  assign full    = cmd_full;
  assign accept  = push && !cmd_full;
  assign w_clamp = clamp(image_width);
  assign h_clamp = clamp(image_height);
  assign filter  = (column_count == '0);

  always_comb begin
    col_next  = (filter ? latched_width : column_count) - DIM_W'(1);
    rows_next = rows_remaining;
    if (col_next == '0 && rows_remaining != '0) rows_next = rows_remaining - DIM_W'(1);
  end

  assign cmd_push = accept && (in_item.command == CMD_START || image_open);

  always_comb begin
    cmd_data.is_start = (in_item.command == CMD_START);
    cmd_data.filter   = filter;
    cmd_data.finish   = (rows_next == '0);
    cmd_data.width    = w_clamp;
    cmd_data.height   = h_clamp;
    cmd_data.pixel    = {in_item.red, in_item.green, in_item.blue, in_item.alpha};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_open     <= 1'b0;
      latched_width  <= DIM_W'(1);
      column_count   <= '0;
      rows_remaining <= '0;
    end else if (accept) begin
      if (in_item.command == CMD_START) begin
        image_open     <= 1'b1;
        latched_width  <= w_clamp;
        column_count   <= '0;
        rows_remaining <= h_clamp;
      end else if (image_open) begin
        column_count   <= col_next;
        rows_remaining <= rows_next;
        if (rows_next == '0) image_open <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pse_cmd_fifo.sv
`default_nettype none
module pse_cmd_fifo import pse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     wr,
  input  wire pse_cmd_t wdata,
  output logic          full,
  output logic          valid,
  output pse_cmd_t      rdata,
  input  wire logic     rd
);

  pse_cmd_t   mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr && !full) wptr <= ~wptr;
      if (rd && valid) rptr <= ~rptr;
      count <= count + {1'b0, wr && !full} - {1'b0, rd && valid};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/pse_back.sv
`default_nettype none
module pse_back import pse_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cmd_valid,
  input  wire pse_cmd_t cmd_data,
  output logic          cmd_pop,
  output logic          empty,
  input  wire logic     pop,
  output pse_out_t      out_item
);

  typedef enum logic [1:0] {S_IDLE, S_START, S_PIX, S_TAIL} state_t;

  state_t           state;
  logic [5:0]       idx;       // byte of the start sequence
  logic [4:0]       tidx;      // byte of the closing sequence
  logic [2:0]       slot;      // 0 filter byte, 1..4 R,G,B,A
  logic [2:0]       hidx;      // stored-block header byte
  logic             finish;
  logic [31:0]      pixel;
  logic [DIM_W-1:0] w_l, h_l;

  logic [RAW_W-1:0] raw_r;
  logic [15:0]      blk_r;
  logic [LEN_W-1:0] len_r;

  logic [RAW_W-1:0] raw_rem;
  logic [15:0]      blk_rem;
  logic [31:0]      crc;
  logic [15:0]      adler_lo, adler_hi;

  // output queue
  pse_out_t   oq [2];
  logic       oq_w, oq_r;
  logic [1:0] oq_cnt;

  logic       out_take, step, last, eoi, use_crc, crc_rst, is_hdr;
  logic [7:0] b;
  logic [7:0] raw_b;
  logic [15:0] blk_size;
  logic [31:0] crc_out;
  logic [16:0] lo_s, lo_n, hi_s, hi_n;
  logic [30:0] x_ceil;
  logic [16:0] r_ceil;
  pse_out_t    emit_item;

  assign empty    = (oq_cnt == 2'd0);
  assign out_item = oq[oq_r];
  assign out_take = pop && !empty;
  assign step     = (state != S_IDLE) && (oq_cnt != 2'd2 || out_take);

  // image geometry, refreshed every cycle from the latched dimensions
  assign x_ceil = {1'b0, raw_r} + 31'd65534;
  assign r_ceil = {1'b0, x_ceil[15:0]} + {2'b0, x_ceil[30:16]};
  always_ff @(posedge clk) begin
    raw_r <= RAW_W'(h_l) * RAW_W'({w_l, 2'b00} | 16'd1);
    blk_r <= {1'b0, x_ceil[30:16]} + {15'd0, r_ceil >= 17'd65535};
    len_r <= LEN_W'(raw_r) + LEN_W'({blk_r, 2'b00}) + LEN_W'(blk_r) + LEN_W'(6);
  end

  assign crc_out  = ~crc;
  assign blk_size = (raw_rem < RAW_W'(BLOCK_MAX)) ? raw_rem[15:0] : BLOCK_MAX;
  assign is_hdr   = (blk_rem == '0);

  always_comb begin
    case (slot)
      3'd0:    raw_b = 8'd0;
      3'd1:    raw_b = pixel[31:24];
      3'd2:    raw_b = pixel[23:16];
      3'd3:    raw_b = pixel[15:8];
      default: raw_b = pixel[7:0];
    endcase
  end

  always_comb begin
    b        = 8'd0;
    use_crc  = 1'b0;
    crc_rst  = 1'b0;
    last     = 1'b0;
    eoi      = 1'b0;
    unique case (state)
      S_START: begin
        use_crc = (idx >= 6'd12 && idx <= 6'd28) || idx >= 6'd37;
        crc_rst = (idx == 6'd12) || (idx == 6'd37);
        last    = (idx == 6'd42);
        case (idx)
          6'd11: b = 8'd13;
          6'd12: b = "I";
          6'd13: b = "H";
          6'd14: b = "D";
          6'd15: b = "R";
          6'd18: b = 8'(w_l >> 8);
          6'd19: b = w_l[7:0];
          6'd22: b = 8'(h_l >> 8);
          6'd23: b = h_l[7:0];
          6'd24: b = 8'd8;
          6'd25: b = 8'd6;
          6'd29: b = crc_out[31:24];
          6'd30: b = crc_out[23:16];
          6'd31: b = crc_out[15:8];
          6'd32: b = crc_out[7:0];
          6'd33: b = len_r[31:24];
          6'd34: b = len_r[23:16];
          6'd35: b = len_r[15:8];
          6'd36: b = len_r[7:0];
          6'd37: b = "I";
          6'd38: b = "D";
          6'd39: b = "A";
          6'd40: b = "T";
          6'd41: b = ZLIB_CMF;
          6'd42: b = ZLIB_FLG;
          default: b = (idx < 6'd8) ? sig_byte(idx[2:0]) : 8'd0;
        endcase
      end
      S_PIX: begin
        use_crc = 1'b1;
        if (is_hdr) begin
          case (hidx)
            3'd0:    b = {7'd0, raw_rem <= RAW_W'(BLOCK_MAX)};
            3'd1:    b = blk_size[7:0];
            3'd2:    b = blk_size[15:8];
            3'd3:    b = ~blk_size[7:0];
            default: b = ~blk_size[15:8];
          endcase
        end else begin
          b        = raw_b;
          last     = (slot == 3'd4) && !finish;
        end
      end
      S_TAIL: begin
        use_crc = (tidx < 5'd4) || (tidx >= 5'd12 && tidx < 5'd16);
        crc_rst = (tidx == 5'd12);
        last    = (tidx == 5'd19);
        eoi     = last;
        case (tidx)
          5'd0:  b = adler_hi[15:8];
          5'd1:  b = adler_hi[7:0];
          5'd2:  b = adler_lo[15:8];
          5'd3:  b = adler_lo[7:0];
          5'd4, 5'd16: b = crc_out[31:24];
          5'd5, 5'd17: b = crc_out[23:16];
          5'd6, 5'd18: b = crc_out[15:8];
          5'd7, 5'd19: b = crc_out[7:0];
          5'd12: b = "I";
          5'd13: b = "E";
          5'd14: b = "N";
          5'd15: b = "D";
          default: b = 8'd0;
        endcase
      end
      default: b = 8'd0;
    endcase
  end

  // Adler-32 running sums
  always_comb begin
    lo_s = {1'b0, adler_lo} + {9'd0, raw_b};
    lo_n = (lo_s >= ADLER_MOD) ? lo_s - ADLER_MOD : lo_s;
    hi_s = {1'b0, adler_hi} + lo_n;
    hi_n = (hi_s >= ADLER_MOD) ? hi_s - ADLER_MOD : hi_s;
  end

  always_comb begin
    emit_item.out_byte     = b;
    emit_item.last_of_run  = last;
    emit_item.end_of_image = eoi;
  end

  assign cmd_pop = cmd_valid && (state == S_IDLE || (step && last));

  always_ff @(posedge clk) begin
    if (step) oq[oq_w] <= emit_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      tidx     <= '0;
      slot     <= '0;
      hidx     <= '0;
      finish   <= 1'b0;
      raw_rem  <= '0;
      blk_rem  <= '0;
      crc      <= CRC_INIT;
      adler_lo <= 16'd1;
      adler_hi <= 16'd0;
      w_l      <= DIM_W'(1);
      h_l      <= DIM_W'(1);
      oq_w     <= 1'b0;
      oq_r     <= 1'b0;
      oq_cnt   <= 2'd0;
    end else begin
      if (step) oq_w <= ~oq_w;
      if (out_take) oq_r <= ~oq_r;
      oq_cnt <= oq_cnt + {1'b0, step} - {1'b0, out_take};

      if (step) begin
        if (use_crc) crc <= crc_byte(crc_rst ? CRC_INIT : crc, b);
        unique case (state)
          S_START: begin
            idx <= idx + 6'd1;
            if (last) begin
              raw_rem  <= raw_r;
              blk_rem  <= '0;
              adler_lo <= 16'd1;
              adler_hi <= 16'd0;
            end
          end
          S_PIX: begin
            if (is_hdr) begin
              if (hidx == 3'd4) begin
                hidx    <= '0;
                blk_rem <= blk_size;
              end else begin
                hidx <= hidx + 3'd1;
              end
            end else begin
              adler_lo <= lo_n[15:0];
              adler_hi <= hi_n[15:0];
              raw_rem  <= raw_rem - RAW_W'(1);
              blk_rem  <= blk_rem - 16'd1;
              slot     <= slot + 3'd1;
              if (slot == 3'd4 && finish) begin
                state <= S_TAIL;
                tidx  <= '0;
              end
            end
          end
          S_TAIL: begin
            tidx <= tidx + 5'd1;
            if (last) crc <= CRC_INIT;
          end
          default: state <= S_IDLE;
        endcase
        if (last) state <= S_IDLE;
      end

      if (cmd_pop) begin
        if (cmd_data.is_start) begin
          state <= S_START;
          idx   <= '0;
          w_l   <= cmd_data.width;
          h_l   <= cmd_data.height;
        end else begin
          state  <= S_PIX;
          slot   <= cmd_data.filter ? 3'd0 : 3'd1;
          hidx   <= '0;
          finish <= cmd_data.finish;
          pixel  <= cmd_data.pixel;
        end
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    step |-> (oq_cnt != 2'd2 || out_take)) else $error("output queue overrun");
  a_eoi_last: assert property (@(posedge clk) disable iff (rst)
    (step && eoi) |-> last) else $error("end of image not on last byte");
  a_pix_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX) |-> (slot <= 3'd4 && hidx <= 3'd4)) else $error("pixel sequencer out of range");
  a_start_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_START && idx == 6'd33) |-> $stable(w_l) && $stable(h_l))
    else $error("dimensions moved during start sequence");

endmodule
`default_nettype wire

### hw/rtl/png_stored_image_encoder_top.sv
`default_nettype none
// PNG encoder for RGBA8 rasters using stored (uncompressed) deflate blocks.
// Write image_width (index 0) and image_height (index 1), then push a start
// item (command 0) followed by width*height pixel items (command 1). The
// result queue yields the PNG file one byte per transfer; last_of_run marks
// the final byte due to each item, end_of_image the last byte of IEND.
// Dimensions are clamped to 1..MAX_DIMENSION and latched at start. A start
// produces 43 bytes; a pixel produces 4 bytes, plus a filter byte at row
// start, plus 5 bytes where a stored block of up to 65535 bytes begins; the
// last pixel adds 20 closing bytes. The output side moves one byte per cycle
// while the byte queue has room or is being popped. A pixel with no open
// image is taken and produces nothing. Input and output are decoupled by a
// two-entry command queue and a two-entry byte queue.
module png_stored_image_encoder_top import pse_pkg::*; #(
  parameter int MAX_DIMENSION = 8192
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  output logic                        full,
  input  wire pse_in_t                in_item,
  output logic                        empty,
  input  wire logic                   pop,
  output pse_out_t                    out_item,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]       cfg_data
);

  logic [DIM_W-1:0] image_width, image_height;
  logic             cmd_push, cmd_full, cmd_valid, cmd_pop;
  pse_cmd_t         cmd_wdata, cmd_rdata;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: tracks rows and columns, tags row start and final pixel
  pse_front #(.MAX_DIMENSION(MAX_DIMENSION)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .in_item      (in_item),
    .image_width  (image_width),
    .image_height (image_height),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_wdata),
    .cmd_full     (cmd_full)
  );

  pse_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .valid (cmd_valid),
    .rdata (cmd_rdata),
    .rd    (cmd_pop)
  );

  // back: byte sequencer with CRC-32, Adler-32 and block framing
  pse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
